@@ design/mlqs_pkg.sv @@
`default_nettype none
package mlqs_pkg;
    localparam int QUEUE_DEPTH_DEF   = 64;
    localparam int TASK_ID_BITS_DEF  = 16;
    localparam int PRIORITY_BITS_DEF = 8;
    localparam logic [7:0]  SLICE_RESET = 8'd4;
    localparam logic [15:0] SAT_MAX     = 16'hFFFF;

    localparam logic [1:0] OP_SUBMIT   = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_FINISH   = 2'd2;
    localparam logic [1:0] OP_TICK     = 2'd3;

    localparam logic [3:0] EV_NONE     = 4'd0;
    localparam logic [3:0] EV_GRANTED  = 4'd1;
    localparam logic [3:0] EV_PREEMPT  = 4'd2;
    localparam logic [3:0] EV_FINISHED = 4'd3;
    localparam logic [3:0] EV_FULL     = 4'd4;
    localparam logic [3:0] EV_EMPTY    = 4'd5;
    localparam logic [3:0] EV_BUSY     = 4'd6;
    localparam logic [3:0] EV_BADLVL   = 4'd7;
    localparam logic [3:0] EV_NORUN    = 4'd8;

    // command from the controller to the priority chain
    typedef struct packed {
        logic push;
        logic scan;
        logic pop;
    } t_chain_cmd;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        sat_inc = (v == SAT_MAX) ? v : v + 16'd1;
    endfunction
endpackage
`default_nettype wire

@@ design/multilevel_queue_scheduler_top.sv @@
`default_nettype none
// Three-level task scheduler: level 1 round robin with slice pre-emption, level 2
// lowest priority first (oldest wins ties), level 3 first come first served.
// Every operation passes through the read, execute and output states; a level-2
// dispatch also scans the priority cell chain one cell a cycle, over the N stored
// level-2 tasks, between execute and output. One word in, one word out.
module multilevel_queue_scheduler_top import mlqs_pkg::*; #(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS  = TASK_ID_BITS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_stall,
    input  wire  [1:0]               i_operation,
    input  wire  [1:0]               i_level,
    input  wire  [PRIORITY_BITS-1:0] i_priority_req,
    input  wire  [TASK_ID_BITS-1:0]  i_task_id,
    output logic                     o_valid,
    input  wire                      i_stall,
    output logic [3:0]               o_event_res,
    output logic [TASK_ID_BITS-1:0]  o_out_task_id,
    output logic [1:0]               o_out_level,
    output logic [PRIORITY_BITS-1:0] o_out_priority,
    output logic [15:0]              o_done_round_robin,
    output logic [15:0]              o_done_priority,
    output logic [15:0]              o_done_fifo,
    output logic [15:0]              o_grant_count,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire  [7:0]               i_cfg_data
);
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = TASK_ID_BITS + PRIORITY_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  r_state;
    logic [1:0]  r_op, r_lvl;
    logic [TASK_ID_BITS-1:0]  r_id;
    logic [PRIORITY_BITS-1:0] r_prio;
    logic [7:0]  r_slice_ticks, r_slice_cnt;

    logic [EW-1:0] r_rr_mem [QUEUE_DEPTH];
    logic [EW-1:0] r_ff_mem [QUEUE_DEPTH];
    logic [EW-1:0] r_rr_rd, r_ff_rd;
    logic [IW-1:0] r_rr_head, r_ff_head;
    logic [CW-1:0] r_rr_cnt, r_ff_cnt;

    logic          r_run_vld;
    logic [1:0]    r_run_lvl;
    logic [TASK_ID_BITS-1:0]  r_run_id;
    logic [PRIORITY_BITS-1:0] r_run_prio;

    logic [15:0] r_done_rr, r_done_pr, r_done_ff, r_grants;
    logic        r_ovld;
    logic [3:0]  r_ev;
    logic [TASK_ID_BITS-1:0]  r_oid;
    logic [1:0]  r_olvl;
    logic [PRIORITY_BITS-1:0] r_oprio;

    t_chain_cmd  w_cmd;
    logic [CW-1:0] w_pr_cnt;
    logic        w_scan_done;
    logic [TASK_ID_BITS-1:0]  w_best_id;
    logic [PRIORITY_BITS-1:0] w_best_prio;

    logic        w_accept;
    logic [7:0]  w_slice_lim;
    logic [7:0]  w_slice_nx;
    logic [IW:0] w_rr_tail_s, w_ff_tail_s;
    logic [IW-1:0] w_rr_tail, w_ff_tail;
    logic        w_rr_push, w_ff_push;
    logic [EW-1:0] w_rr_wd;

    assign w_accept    = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE) || r_ovld;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_slice_lim = (r_slice_ticks == 8'd0) ? 8'd1 : r_slice_ticks;
    assign w_slice_nx  = r_slice_cnt + 8'd1;

    assign w_rr_tail_s = {1'b0, r_rr_head} + (IW+1)'(r_rr_cnt);
    assign w_ff_tail_s = {1'b0, r_ff_head} + (IW+1)'(r_ff_cnt);
    assign w_rr_tail = (w_rr_tail_s >= (IW+1)'(QUEUE_DEPTH)) ?
                       IW'(w_rr_tail_s - (IW+1)'(QUEUE_DEPTH)) : IW'(w_rr_tail_s);
    assign w_ff_tail = (w_ff_tail_s >= (IW+1)'(QUEUE_DEPTH)) ?
                       IW'(w_ff_tail_s - (IW+1)'(QUEUE_DEPTH)) : IW'(w_ff_tail_s);

    logic w_rr_full, w_ff_full, w_pr_full, w_preempt;
    assign w_rr_full = (r_rr_cnt == CW'(QUEUE_DEPTH));
    assign w_ff_full = (r_ff_cnt == CW'(QUEUE_DEPTH));
    assign w_pr_full = (w_pr_cnt == CW'(QUEUE_DEPTH));
    assign w_preempt = (r_state == S_EXEC) && (r_op == OP_TICK) && r_run_vld
                       && (r_run_lvl == 2'd1) && (w_slice_nx >= w_slice_lim);

    assign w_rr_push = (r_state == S_EXEC) &&
        (((r_op == OP_SUBMIT) && (r_lvl == 2'd1) && !w_rr_full) ||
         (w_preempt && !w_rr_full));
    assign w_ff_push = (r_state == S_EXEC) && (r_op == OP_SUBMIT) && (r_lvl == 2'd3)
                       && !w_ff_full;
    assign w_rr_wd = (r_op == OP_SUBMIT) ? {r_id, r_prio} : {r_run_id, r_run_prio};

    logic w_dispatch_pr;
    assign w_dispatch_pr = (r_op == OP_DISPATCH) && !r_run_vld && (r_rr_cnt == '0)
                           && (w_pr_cnt != '0);

    always_comb begin
        w_cmd.push = (r_state == S_EXEC) && (r_op == OP_SUBMIT) && (r_lvl == 2'd2)
                     && !w_pr_full;
        w_cmd.scan = (r_state == S_SCAN) && !w_scan_done;
        w_cmd.pop  = (r_state == S_SCAN) && w_scan_done;
    end

    mlqs_chain #(.QUEUE_DEPTH(QUEUE_DEPTH), .TASK_ID_BITS(TASK_ID_BITS),
                 .PRIORITY_BITS(PRIORITY_BITS)) u_chain (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_new_id(r_id), .i_new_prio(r_prio),
        .o_count(w_pr_cnt), .o_scan_done(w_scan_done),
        .o_best_id(w_best_id), .o_best_prio(w_best_prio)
    );

    always_ff @(posedge i_clk) begin
        if (w_rr_push) r_rr_mem[w_rr_tail] <= w_rr_wd;
        if (w_ff_push) r_ff_mem[w_ff_tail] <= {r_id, r_prio};
        r_rr_rd <= r_rr_mem[r_rr_head];
        r_ff_rd <= r_ff_mem[r_ff_head];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_operation;
            r_lvl  <= i_level;
            r_id   <= i_task_id;
            r_prio <= i_priority_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slice_ticks <= SLICE_RESET;
            r_slice_cnt <= '0;
            r_rr_head <= '0; r_rr_cnt <= '0;
            r_ff_head <= '0; r_ff_cnt <= '0;
            r_run_vld <= 1'b0; r_run_lvl <= '0;
            r_done_rr <= '0; r_done_pr <= '0; r_done_ff <= '0; r_grants <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (r_ovld && !i_stall) r_ovld <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_slice_ticks <= i_cfg_data;
            if (w_rr_push) r_rr_cnt <= r_rr_cnt + CW'(1);
            if (w_ff_push) r_ff_cnt <= r_ff_cnt + CW'(1);
            unique case (r_state)
                S_IDLE: if (w_accept) r_state <= S_READ;
                S_READ: r_state <= S_EXEC;
                S_EXEC: begin
                    r_state <= S_OUT;
                    r_ev   <= EV_NONE;
                    r_oid  <= '0; r_olvl <= '0; r_oprio <= '0;
                    case (r_op)
                        OP_SUBMIT: begin
                            if (r_lvl == 2'd0) r_ev <= EV_BADLVL;
                            else if ((r_lvl == 2'd1 && w_rr_full) ||
                                     (r_lvl == 2'd2 && w_pr_full) ||
                                     (r_lvl == 2'd3 && w_ff_full)) r_ev <= EV_FULL;
                        end
                        OP_DISPATCH: begin
                            if (r_run_vld) r_ev <= EV_BUSY;
                            else if (r_rr_cnt != '0) begin
                                r_ev <= EV_GRANTED;
                                r_run_vld <= 1'b1; r_run_lvl <= 2'd1;
                                r_run_id <= r_rr_rd[EW-1:PRIORITY_BITS];
                                r_run_prio <= r_rr_rd[PRIORITY_BITS-1:0];
                                r_slice_cnt <= '0;
                                r_grants <= sat_inc(r_grants);
                                r_rr_head <= (r_rr_head == IW'(QUEUE_DEPTH-1)) ? '0
                                             : r_rr_head + IW'(1);
                                r_rr_cnt <= r_rr_cnt - CW'(1);
                                r_oid <= r_rr_rd[EW-1:PRIORITY_BITS];
                                r_olvl <= 2'd1;
                                r_oprio <= r_rr_rd[PRIORITY_BITS-1:0];
                            end else if (w_dispatch_pr) begin
                                r_state <= S_SCAN;
                            end else if (r_ff_cnt != '0) begin
                                r_ev <= EV_GRANTED;
                                r_run_vld <= 1'b1; r_run_lvl <= 2'd3;
                                r_run_id <= r_ff_rd[EW-1:PRIORITY_BITS];
                                r_run_prio <= r_ff_rd[PRIORITY_BITS-1:0];
                                r_slice_cnt <= '0;
                                r_grants <= sat_inc(r_grants);
                                r_ff_head <= (r_ff_head == IW'(QUEUE_DEPTH-1)) ? '0
                                             : r_ff_head + IW'(1);
                                r_ff_cnt <= r_ff_cnt - CW'(1);
                                r_oid <= r_ff_rd[EW-1:PRIORITY_BITS];
                                r_olvl <= 2'd3;
                                r_oprio <= r_ff_rd[PRIORITY_BITS-1:0];
                            end else r_ev <= EV_EMPTY;
                        end
                        OP_FINISH: begin
                            if (!r_run_vld) r_ev <= EV_NORUN;
                            else begin
                                r_ev <= EV_FINISHED;
                                r_oid <= r_run_id; r_olvl <= r_run_lvl;
                                r_oprio <= r_run_prio;
                                if (r_run_lvl == 2'd1) r_done_rr <= sat_inc(r_done_rr);
                                else if (r_run_lvl == 2'd2) r_done_pr <= sat_inc(r_done_pr);
                                else r_done_ff <= sat_inc(r_done_ff);
                                r_run_vld <= 1'b0; r_run_lvl <= '0;
                                r_slice_cnt <= '0;
                            end
                        end
                        default: begin
                            if (r_run_vld && r_run_lvl == 2'd1) begin
                                if (w_preempt) begin
                                    r_slice_cnt <= '0;
                                    if (!w_rr_full) begin
                                        r_ev <= EV_PREEMPT;
                                        r_oid <= r_run_id; r_olvl <= 2'd1;
                                        r_oprio <= r_run_prio;
                                        r_run_vld <= 1'b0; r_run_lvl <= '0;
                                    end
                                end else r_slice_cnt <= w_slice_nx;
                            end
                        end
                    endcase
                end
                S_SCAN: begin
                    if (w_scan_done) begin
                        r_state <= S_OUT;
                        r_ev <= EV_GRANTED;
                        r_run_vld <= 1'b1; r_run_lvl <= 2'd2;
                        r_run_id <= w_best_id; r_run_prio <= w_best_prio;
                        r_slice_cnt <= '0;
                        r_grants <= sat_inc(r_grants);
                        r_oid <= w_best_id; r_olvl <= 2'd2;
                        r_oprio <= w_best_prio;
                    end
                end
                S_OUT: begin
                    r_ovld  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid            = r_ovld;
    assign o_event_res        = r_ev;
    assign o_out_task_id      = r_oid;
    assign o_out_level        = r_olvl;
    assign o_out_priority     = r_oprio;
    assign o_done_round_robin = r_done_rr;
    assign o_done_priority    = r_done_pr;
    assign o_done_fifo        = r_done_ff;
    assign o_grant_count      = r_grants;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !w_accept) else $error("accept while busy");
    a_rr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rr_cnt <= CW'(QUEUE_DEPTH)) else $error("rr count overflow");
    a_run_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_vld |-> (r_run_lvl != 2'd0)) else $error("running without level");
endmodule
`default_nettype wire

@@ design/mlqs_cell.sv @@
`default_nettype none
// one slot of the compacted priority store
module mlqs_cell import mlqs_pkg::*; #(
    parameter int TASK_ID_BITS  = TASK_ID_BITS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire t_chain_cmd          i_cmd,
    input  wire                      i_is_tail,
    input  wire                      i_is_sel,
    input  wire                      i_past_sel,
    input  wire [TASK_ID_BITS-1:0]   i_new_id,
    input  wire [PRIORITY_BITS-1:0]  i_new_prio,
    input  wire                      i_next_vld,
    input  wire [TASK_ID_BITS-1:0]   i_next_id,
    input  wire [PRIORITY_BITS-1:0]  i_next_prio,
    output logic                     o_vld,
    output logic [TASK_ID_BITS-1:0]  o_id,
    output logic [PRIORITY_BITS-1:0] o_prio
);
    logic                     r_vld;
    logic [TASK_ID_BITS-1:0]  r_id;
    logic [PRIORITY_BITS-1:0] r_prio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_cmd.push && i_is_tail) begin
            r_vld <= 1'b1;
        end else if (i_cmd.pop && (i_is_sel || i_past_sel)) begin
            r_vld <= i_next_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && i_is_tail) begin
            r_id   <= i_new_id;
            r_prio <= i_new_prio;
        end else if (i_cmd.pop && (i_is_sel || i_past_sel)) begin
            r_id   <= i_next_id;
            r_prio <= i_next_prio;
        end
    end

    assign o_vld  = r_vld;
    assign o_id   = r_id;
    assign o_prio = r_prio;
endmodule
`default_nettype wire

@@ design/mlqs_chain.sv @@
`default_nettype none
// compacted priority store, scanned one cell a cycle for the minimum
module mlqs_chain import mlqs_pkg::*; #(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS  = TASK_ID_BITS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
    localparam int IW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire t_chain_cmd          i_cmd,
    input  wire [TASK_ID_BITS-1:0]   i_new_id,
    input  wire [PRIORITY_BITS-1:0]  i_new_prio,
    output logic [CW-1:0]            o_count,
    output logic                     o_scan_done,
    output logic [TASK_ID_BITS-1:0]  o_best_id,
    output logic [PRIORITY_BITS-1:0] o_best_prio
);
    logic [QUEUE_DEPTH-1:0]   w_vld;
    logic [TASK_ID_BITS-1:0]  w_id   [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] w_prio [QUEUE_DEPTH];
    logic [CW-1:0]            r_count;
    logic [IW-1:0]            r_scan;
    logic [IW-1:0]            r_best;
    logic [PRIORITY_BITS-1:0] r_best_prio;
    logic [TASK_ID_BITS-1:0]  r_best_id;
    logic                     r_done;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                     w_nv;
        logic [TASK_ID_BITS-1:0]  w_ni;
        logic [PRIORITY_BITS-1:0] w_np;
        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_nv = 1'b0;
            assign w_ni = '0;
            assign w_np = '0;
        end else begin : g_mid
            assign w_nv = w_vld[g+1];
            assign w_ni = w_id[g+1];
            assign w_np = w_prio[g+1];
        end
        mlqs_cell #(.TASK_ID_BITS(TASK_ID_BITS), .PRIORITY_BITS(PRIORITY_BITS)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(i_cmd),
            .i_is_tail(r_count == CW'(g)),
            .i_is_sel(r_best == IW'(g)),
            .i_past_sel(r_best < IW'(g)),
            .i_new_id(i_new_id), .i_new_prio(i_new_prio),
            .i_next_vld(w_nv), .i_next_id(w_ni), .i_next_prio(w_np),
            .o_vld(w_vld[g]), .o_id(w_id[g]), .o_prio(w_prio[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
            r_scan  <= '0;
            r_best  <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.pop) begin
            r_count <= r_count - CW'(1);
            r_done  <= 1'b0;
        end else if (i_cmd.scan) begin
            if (r_scan == '0 && !r_done) begin
                r_best      <= '0;
                r_best_prio <= w_prio[0];
                r_best_id   <= w_id[0];
                r_scan      <= IW'(1);
                if (r_count == CW'(1)) r_done <= 1'b1;
            end else if (!r_done) begin
                if (w_prio[r_scan] < r_best_prio) begin
                    r_best      <= r_scan;
                    r_best_prio <= w_prio[r_scan];
                    r_best_id   <= w_id[r_scan];
                end
                if ((CW+1)'(r_scan) + (CW+1)'(1) >= (CW+1)'(r_count)) begin
                    r_done <= 1'b1;
                end
                r_scan <= r_scan + IW'(1);
            end
        end else begin
            r_scan <= '0;
        end
    end

    assign o_count     = r_count;
    assign o_scan_done = r_done;
    assign o_best_id   = r_best_id;
    assign o_best_prio = r_best_prio;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH)) else $error("priority count overflow");
    a_vld_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> w_vld[0]) else $error("head cell invalid");
    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |=> r_count == $past(r_count) - CW'(1)) else $error("pop count");
endmodule
`default_nettype wire

@@ bench/multilevel_queue_scheduler_top_tb.sv @@
`default_nettype none
module multilevel_queue_scheduler_top_tb;
    import mlqs_pkg::*;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  level;
        logic [7:0]  priority_req;
        logic [15:0] task_id;
    } sched_word_t;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [15:0] task_id;
        logic [1:0]  level;
        logic [7:0]  priority_val;
        logic [15:0] done_rr;
        logic [15:0] done_prio;
        logic [15:0] done_fifo;
        logic [15:0] grants;
    } sched_result_t;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
    } task_entry_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  in_operation = '0;
    logic [1:0]  in_level = '0;
    logic [7:0]  in_priority = '0;
    logic [15:0] in_task_id = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  out_event;
    logic [15:0] out_task_id;
    logic [1:0]  out_level;
    logic [7:0]  out_priority;
    logic [15:0] out_done_rr;
    logic [15:0] out_done_prio;
    logic [15:0] out_done_fifo;
    logic [15:0] out_grants;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    multilevel_queue_scheduler_top u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_operation(in_operation), .i_level(in_level),
        .i_priority_req(in_priority), .i_task_id(in_task_id),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_event_res(out_event), .o_out_task_id(out_task_id),
        .o_out_level(out_level), .o_out_priority(out_priority),
        .o_done_round_robin(out_done_rr), .o_done_priority(out_done_prio),
        .o_done_fifo(out_done_fifo), .o_grant_count(out_grants),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // scheduler shadow state
    logic [7:0]    slice_len;
    task_entry_t   rr_tasks[$];
    task_entry_t   prio_tasks[$];
    task_entry_t   fifo_tasks[$];
    logic          busy;
    logic [1:0]    busy_level;
    task_entry_t   busy_task;
    logic [7:0]    slice_used;
    logic [15:0]   n_done_rr, n_done_prio, n_done_fifo, n_grants;

    sched_word_t   pending_words[$];
    sched_result_t expected_results[$];
    int            mismatches = 0;
    int            cycles = 0;
    logic          hold_sender = 1'b0;

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    task automatic reset_shadow();
        slice_len = SLICE_RESET;
        rr_tasks.delete();
        prio_tasks.delete();
        fifo_tasks.delete();
        busy = 1'b0;
        busy_level = 2'd0;
        busy_task = '0;
        slice_used = '0;
        n_done_rr = '0;
        n_done_prio = '0;
        n_done_fifo = '0;
        n_grants = '0;
    endtask

    task automatic start_task(input logic [1:0] lvl, input task_entry_t t);
        busy = 1'b1;
        busy_level = lvl;
        busy_task = t;
        slice_used = '0;
        n_grants = bump(n_grants);
    endtask

    task automatic schedule_word(input sched_word_t w);
        sched_result_t r;
        task_entry_t   t;
        int            best;
        logic          show;
        r = '0;
        show = 1'b0;
        t.id = w.task_id;
        t.prio = w.priority_req;
        case (w.operation)
            OP_SUBMIT: begin
                if (w.level == 2'd0) begin
                    r.event_res = EV_BADLVL;
                end else if (w.level == 2'd1) begin
                    if (rr_tasks.size() < DEPTH) rr_tasks.push_back(t);
                    else r.event_res = EV_FULL;
                end else if (w.level == 2'd2) begin
                    if (prio_tasks.size() < DEPTH) prio_tasks.push_back(t);
                    else r.event_res = EV_FULL;
                end else begin
                    if (fifo_tasks.size() < DEPTH) fifo_tasks.push_back(t);
                    else r.event_res = EV_FULL;
                end
            end
            OP_DISPATCH: begin
                if (busy) begin
                    r.event_res = EV_BUSY;
                end else if (rr_tasks.size() > 0) begin
                    start_task(2'd1, rr_tasks.pop_front());
                    r.event_res = EV_GRANTED;
                end else if (prio_tasks.size() > 0) begin
                    best = 0;
                    for (int i = 1; i < prio_tasks.size(); i++)
                        if (prio_tasks[i].prio < prio_tasks[best].prio) best = i;
                    t = prio_tasks[best];
                    prio_tasks.delete(best);
                    start_task(2'd2, t);
                    r.event_res = EV_GRANTED;
                end else if (fifo_tasks.size() > 0) begin
                    start_task(2'd3, fifo_tasks.pop_front());
                    r.event_res = EV_GRANTED;
                end else begin
                    r.event_res = EV_EMPTY;
                end
                show = (r.event_res == EV_GRANTED);
                if (show) begin
                    r.task_id = busy_task.id;
                    r.priority_val = busy_task.prio;
                    r.level = busy_level;
                end
            end
            OP_FINISH: begin
                if (!busy) begin
                    r.event_res = EV_NORUN;
                end else begin
                    r.event_res = EV_FINISHED;
                    r.task_id = busy_task.id;
                    r.priority_val = busy_task.prio;
                    r.level = busy_level;
                    if (busy_level == 2'd1) n_done_rr = bump(n_done_rr);
                    else if (busy_level == 2'd2) n_done_prio = bump(n_done_prio);
                    else n_done_fifo = bump(n_done_fifo);
                    busy = 1'b0;
                    busy_level = 2'd0;
                    slice_used = '0;
                end
            end
            default: begin
                if (busy && busy_level == 2'd1) begin
                    slice_used = slice_used + 8'd1;
                    if (slice_used >= slice_len) begin
                        if (rr_tasks.size() < DEPTH) begin
                            rr_tasks.push_back(busy_task);
                            r.event_res = EV_PREEMPT;
                            r.task_id = busy_task.id;
                            r.priority_val = busy_task.prio;
                            r.level = 2'd1;
                            busy = 1'b0;
                            busy_level = 2'd0;
                        end
                        slice_used = '0;
                    end
                end
            end
        endcase
        r.done_rr = n_done_rr;
        r.done_prio = n_done_prio;
        r.done_fifo = n_done_fifo;
        r.grants = n_grants;
        expected_results.push_back(r);
    endtask

    // driver
    int send_gap = 0;
    always @(posedge clk) begin
        sched_word_t w;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                schedule_word({in_operation, in_level, in_priority, in_task_id});
                send_gap = $urandom_range(0, 7);
            end
            if (in_valid && in_stall) begin
            end else if (send_gap > 0) begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end else if (!(hold_sender && expected_results.size() > 0) &&
                         pending_words.size() > 0) begin
                w = pending_words.pop_front();
                in_valid <= 1'b1;
                in_operation <= w.operation;
                in_level <= w.level;
                in_priority <= w.priority_req;
                in_task_id <= w.task_id;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    int recv_gap = 0;
    always @(posedge clk) begin
        sched_result_t got, want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got = {out_event, out_task_id, out_level, out_priority,
                       out_done_rr, out_done_prio, out_done_fifo, out_grants};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp ev=%0d id=%h lvl=%0d pr=%h cnt=%h %h %h %h",
                                     want.event_res, want.task_id, want.level,
                                     want.priority_val, want.done_rr, want.done_prio,
                                     want.done_fifo, want.grants);
                        if (mismatches <= 10)
                            $display("          got ev=%0d id=%h lvl=%0d pr=%h cnt=%h %h %h %h",
                                     got.event_res, got.task_id, got.level,
                                     got.priority_val, got.done_rr, got.done_prio,
                                     got.done_fifo, got.grants);
                    end
                end
                recv_gap = $urandom_range(0, 7);
            end
            if (out_valid && !out_stall) out_stall <= (recv_gap > 0);
            else if (recv_gap > 0) begin
                recv_gap = recv_gap - 1;
                out_stall <= (recv_gap > 0);
            end else out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout");
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic sched_word_t mk(input logic [1:0] op, input logic [1:0] lvl,
                                       input logic [7:0] pr, input logic [15:0] id);
        return {op, lvl, pr, id};
    endfunction

    task automatic drain();
        while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_slice(input logic [7:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        slice_len = v;
    endtask

    // random bursts: submits at levels 1 to 3, dispatches, finishes, ticks and level-0 submits, mixed
    task automatic add_random_phase(input int n);
        int k, pick;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                pending_words.push_back(mk(OP_SUBMIT, 2'($urandom_range(1, 3)),
                    ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 7)),
                    16'($urandom_range(0, 65535))));
            else if (pick < 55) pending_words.push_back(mk(OP_DISPATCH,
                    2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535))));
            else if (pick < 70) pending_words.push_back(mk(OP_FINISH,
                    2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535))));
            else if (pick < 95) pending_words.push_back(mk(OP_TICK,
                    2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535))));
            else pending_words.push_back(mk(OP_SUBMIT, 2'd0, 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535))));
        end
    endtask

    initial begin
        reset_shadow();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        pending_words.push_back(mk(OP_DISPATCH, 2'd0, 8'h00, 16'h0000));
        pending_words.push_back(mk(OP_FINISH, 2'd0, 8'h00, 16'h0000));
        pending_words.push_back(mk(OP_TICK, 2'd0, 8'h00, 16'h0000));
        pending_words.push_back(mk(OP_SUBMIT, 2'd0, 8'hFF, 16'hFFFF));
        pending_words.push_back(mk(OP_SUBMIT, 2'd3, 8'hFF, 16'hFFFF));
        pending_words.push_back(mk(OP_SUBMIT, 2'd2, 8'hFF, 16'h1111));
        pending_words.push_back(mk(OP_SUBMIT, 2'd2, 8'h05, 16'h2222));
        pending_words.push_back(mk(OP_SUBMIT, 2'd2, 8'h05, 16'h3333));
        pending_words.push_back(mk(OP_SUBMIT, 2'd2, 8'h00, 16'h4444));
        pending_words.push_back(mk(OP_SUBMIT, 2'd1, 8'h00, 16'h0000));
        pending_words.push_back(mk(OP_DISPATCH, 2'd0, 8'h00, 16'h0000));
        pending_words.push_back(mk(OP_DISPATCH, 2'd0, 8'h00, 16'h0000));
        for (int i = 0; i < 4; i++) pending_words.push_back(mk(OP_TICK, 2'd0, 8'h00, 16'h0));
        pending_words.push_back(mk(OP_DISPATCH, 2'd0, 8'h00, 16'h0000));
        pending_words.push_back(mk(OP_FINISH, 2'd0, 8'h00, 16'h0000));
        for (int i = 0; i < 5; i++) begin
            pending_words.push_back(mk(OP_DISPATCH, 2'd0, 8'h00, 16'h0000));
            pending_words.push_back(mk(OP_TICK, 2'd0, 8'h00, 16'h0000));
            pending_words.push_back(mk(OP_FINISH, 2'd0, 8'h00, 16'h0000));
        end
        drain();

        // fill every level one word at a time, each result awaited, then full handling
        write_slice(8'd1);
        for (int i = 0; i < 65; i++) begin
            pending_words.push_back(mk(OP_SUBMIT, 2'd1, i[7:0], i[15:0]));
            pending_words.push_back(mk(OP_SUBMIT, 2'd2, 8'($urandom_range(0, 255)),
                                       i[15:0]));
            pending_words.push_back(mk(OP_SUBMIT, 2'd3, 8'hAA, i[15:0]));
        end
        hold_sender = 1'b1;
        drain();
        hold_sender = 1'b0;
        pending_words.push_back(mk(OP_DISPATCH, 2'd0, 8'h00, 16'h0000));
        pending_words.push_back(mk(OP_TICK, 2'd0, 8'h00, 16'h0000));
        pending_words.push_back(mk(OP_SUBMIT, 2'd1, 8'h00, 16'hBEEF));
        pending_words.push_back(mk(OP_TICK, 2'd0, 8'h00, 16'h0000));
        pending_words.push_back(mk(OP_FINISH, 2'd0, 8'h00, 16'h0000));
        for (int i = 0; i < 200; i++) begin
            pending_words.push_back(mk(OP_DISPATCH, 2'd0, 8'h00, 16'h0000));
            pending_words.push_back(mk(OP_FINISH, 2'd0, 8'h00, 16'h0000));
        end
        drain();

        write_slice(8'd0);
        add_random_phase(150);
        drain();
        write_slice(8'd255);
        add_random_phase(150);
        drain();
        write_slice(8'd3);
        add_random_phase(200);
        drain();
        write_slice(8'($urandom_range(1, 8)));
        add_random_phase(150);
        drain();

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
design/mlqs_pkg.sv
design/mlqs_cell.sv
design/mlqs_chain.sv
design/multilevel_queue_scheduler_top.sv
bench/multilevel_queue_scheduler_top_tb.sv
